// ===== hw/rtl/hbsn_pkg.sv =====
// Shared types, codes and constants of the HDLC line encoder.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package hbsn_pkg;

    // Line coding modes held in the line_mode register.
    localparam logic [1:0] MODE_PLAIN    = 2'd0;
    localparam logic [1:0] MODE_NRZI     = 2'd1;
    localparam logic [1:0] MODE_NRZI_SCR = 2'd2;
    localparam logic [1:0] LINE_MODE_RESET = MODE_NRZI_SCR;

    // Input item kinds.
    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_FLAG = 1'b1;

    // Bit stuffing and scrambler constants.
    localparam int          BYTE_BITS = 8;
    localparam logic [2:0]  STUFF_RUN = 3'd5;
    localparam int          SCR_W     = 17;
    localparam int          SCR_TAP   = 5;

    // Default queue depths.
    localparam int DEFAULT_IN_DEPTH  = 2;
    localparam int DEFAULT_OUT_DEPTH = 2;

    // One classified input item.
    typedef struct packed {
        logic       is_flag;
        logic       sof;
        logic [7:0] data_byte;
    } item_t;

    // One line bit result.
    typedef struct packed {
        logic line_bit;
        logic is_stuffed;
        logic last_of_item;
    } result_t;

endpackage

// ===== hw/rtl/hbsn_front.sv =====
// Front part: accepts input items, classifies them and queues them.
// Depends on hbsn_pkg.
`timescale 1ns / 1ps

module hbsn_front #(
    parameter int DEPTH = hbsn_pkg::DEFAULT_IN_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                func,
    input  logic [7:0]          data_byte,
    input  logic                start_of_frame,
    output logic                item_valid,
    output hbsn_pkg::item_t     item,
    input  logic                item_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hbsn_pkg::item_t    store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;
    hbsn_pkg::item_t    new_item;

    // Classify the incoming item.
    always_comb
    begin
        new_item.is_flag   = (func == hbsn_pkg::FUNC_FLAG);
        new_item.sof       = start_of_frame;
        new_item.data_byte = data_byte;
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = store_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_pop && item_valid;

    // Pointer and occupancy updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= new_item;
        end
    end

`ifndef SYNTHESIS
    // Occupancy never passes the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
    else $error("input queue overfilled");
`endif

endmodule

// ===== hw/rtl/hbsn_back.sv =====
// Back part: serializes queued items one line bit per cycle while res_full is
// low, applies bit stuffing and the selected line coding. Depends on hbsn_pkg.
`timescale 1ns / 1ps

module hbsn_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          line_mode,
    input  logic                item_valid,
    input  hbsn_pkg::item_t     item,
    output logic                item_pop,
    output logic                res_push,
    output hbsn_pkg::result_t   res,
    input  logic                res_full
);

    localparam int SCR_W = hbsn_pkg::SCR_W;

    // Encoder state.
    logic               nrzi_reg, nrzi_next;
    logic [SCR_W-1:0]   scr_reg, scr_next;
    logic [2:0]         ones_reg, ones_next;
    // Serializer control.
    logic               busy_reg, busy_next;
    logic               stuff_reg, stuff_next;
    logic [3:0]         idx_reg, idx_next;
    // Current item payload.
    logic [7:0]         byte_reg, byte_next;
    logic               flag_reg;

    logic               load, step, cur_flag, stuff_now, raw_bit, last;
    logic [7:0]         cur_byte;
    logic               nrzi_eff;
    logic [SCR_W-1:0]   scr_eff;
    logic [2:0]         ones_eff, ones_inc;
    logic [3:0]         idx_cur;
    logic               enc_bit;

    // Select the bit source and the state it sees.
    always_comb
    begin
        load      = !busy_reg && item_valid;
        step      = (busy_reg || item_valid) && !res_full;
        cur_flag  = busy_reg ? flag_reg : item.is_flag;
        cur_byte  = busy_reg ? byte_reg : item.data_byte;
        nrzi_eff  = (load && item.sof) ? 1'b0 : nrzi_reg;
        scr_eff   = (load && item.sof) ? '0 : scr_reg;
        ones_eff  = (load && (item.sof || item.is_flag)) ? 3'd0 : ones_reg;
        idx_cur   = busy_reg ? idx_reg : 4'd0;
        stuff_now = busy_reg && stuff_reg;
        raw_bit   = stuff_now ? 1'b0 : cur_byte[7];
        ones_inc  = ones_eff + 3'd1;
    end

    // Line coding of the current bit.
    always_comb
    begin
        nrzi_next = nrzi_eff;
        scr_next  = scr_eff;
        enc_bit   = raw_bit;
        unique case (line_mode)
            hbsn_pkg::MODE_NRZI:
            begin
                nrzi_next = nrzi_eff ^ ~raw_bit;
                enc_bit   = nrzi_next;
            end
            hbsn_pkg::MODE_NRZI_SCR:
            begin
                nrzi_next = nrzi_eff ^ ~raw_bit;
                enc_bit   = nrzi_next ^ scr_eff[0] ^ scr_eff[hbsn_pkg::SCR_TAP];
                scr_next  = {enc_bit, scr_eff[SCR_W-1:1]};
            end
            default:
            begin
                enc_bit = raw_bit;
            end
        endcase
    end

    // Bit stuffing and item sequencing.
    always_comb
    begin
        ones_next  = ones_eff;
        stuff_next = 1'b0;
        idx_next   = idx_cur;
        byte_next  = cur_byte;
        if (stuff_now)
        begin
            last = (idx_cur == 4'(hbsn_pkg::BYTE_BITS));
        end
        else
        begin
            idx_next  = idx_cur + 4'd1;
            byte_next = {cur_byte[6:0], 1'b0};
            if (!cur_flag)
            begin
                ones_next = raw_bit ? ones_inc : 3'd0;
                if (ones_next >= hbsn_pkg::STUFF_RUN)
                begin
                    ones_next  = 3'd0;
                    stuff_next = 1'b1;
                end
            end
            last = (idx_cur == 4'(hbsn_pkg::BYTE_BITS - 1)) && !stuff_next;
        end
        busy_next = !last;
    end

    assign item_pop       = load && step;
    assign res_push       = step;
    assign res.line_bit   = enc_bit;
    assign res.is_stuffed = stuff_now;
    assign res.last_of_item = last;

    // Control and encoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nrzi_reg  <= 1'b0;
            scr_reg   <= '0;
            ones_reg  <= 3'd0;
            busy_reg  <= 1'b0;
            stuff_reg <= 1'b0;
            idx_reg   <= 4'd0;
        end
        else if (step)
        begin
            nrzi_reg  <= nrzi_next;
            scr_reg   <= scr_next;
            ones_reg  <= ones_next;
            busy_reg  <= busy_next;
            stuff_reg <= stuff_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload of the item in progress.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            byte_reg <= byte_next;
            flag_reg <= cur_flag;
        end
    end

`ifndef SYNTHESIS
    // A pending stuffing zero belongs to an item in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        stuff_reg |-> busy_reg)
    else $error("stuffing zero pending without an item");

    // A new item is taken only between items.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> !busy_reg)
    else $error("item popped while another is in progress");

    // The stored run of ones never reaches the stuffing length.
    assert property (@(posedge clk) disable iff (!rst_n)
        ones_reg < hbsn_pkg::STUFF_RUN)
    else $error("ones run not cleared after stuffing");

    // Data bit index stays within one byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= 4'(hbsn_pkg::BYTE_BITS))
    else $error("bit index out of range");
`endif

endmodule

// ===== hw/rtl/hbsn_out_queue.sv =====
// Result queue: holds encoded line bits until the consumer pops them.
// Depends on hbsn_pkg.
`timescale 1ns / 1ps

module hbsn_out_queue #(
    parameter int DEPTH = hbsn_pkg::DEFAULT_OUT_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_push,
    input  hbsn_pkg::result_t   res,
    output logic                res_full,
    output logic                empty,
    input  logic                pop,
    output logic                line_bit,
    output logic                is_stuffed,
    output logic                last_of_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hbsn_pkg::result_t  store_reg [DEPTH];
    hbsn_pkg::result_t  head;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign res_full     = (count_reg == CNT_W'(DEPTH));
    assign empty        = (count_reg == '0);
    assign do_push      = res_push && !res_full;
    assign do_pop       = pop && !empty;
    assign head         = store_reg[rd_ptr_reg];
    assign line_bit     = head.line_bit;
    assign is_stuffed   = head.is_stuffed;
    assign last_of_item = head.last_of_item;

    // Pointer and occupancy updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= res;
        end
    end

`ifndef SYNTHESIS
    // A result is never offered to a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
    else $error("result pushed into full queue");
`endif

endmodule

// ===== hw/rtl/hdlc_bit_stuff_nrzi_scrambler_top.sv =====
// Path: an accepted item is queued in hbsn_front and serialized by hbsn_back, and
// each line bit is registered in the result queue before it reaches the result ports.
// Throughput: one line bit per cycle while the result queue has room; an item gives 8
// bits plus up to two stuffing zeros; the bit serializer in hbsn_back sets this rate.
// Reset: rst_n asynchronous, active low; clears both queues, the NRZI level,
// the scrambler and the ones count, and sets line_mode to 2 (NRZI + scrambler).
`timescale 1ns / 1ps

module hdlc_bit_stuff_nrzi_scrambler_top #(
    parameter int IN_DEPTH  = hbsn_pkg::DEFAULT_IN_DEPTH,
    parameter int OUT_DEPTH = hbsn_pkg::DEFAULT_OUT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        line_mode_we,
    input  logic [1:0]  line_mode_wdata,
    input  logic        push,
    output logic        full,
    input  logic        func,
    input  logic [7:0]  data_byte,
    input  logic        start_of_frame,
    output logic        empty,
    input  logic        pop,
    output logic        line_bit,
    output logic        is_stuffed,
    output logic        last_of_item
);

    logic               [1:0] line_mode_reg;
    logic               item_valid, item_pop;
    hbsn_pkg::item_t    item;
    logic               res_push, res_full;
    hbsn_pkg::result_t  res;

    // Line mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_mode_reg <= hbsn_pkg::LINE_MODE_RESET;
        end
        else if (line_mode_we)
        begin
            line_mode_reg <= line_mode_wdata;
        end
    end

    // Input side: accept and queue items.
    hbsn_front #(
        .DEPTH(IN_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .func           (func),
        .data_byte      (data_byte),
        .start_of_frame (start_of_frame),
        .item_valid     (item_valid),
        .item           (item),
        .item_pop       (item_pop)
    );

    // Bit engine.
    hbsn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_mode  (line_mode_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_push   (res_push),
        .res        (res),
        .res_full   (res_full)
    );

    // Output side: queue line bits for the consumer.
    hbsn_out_queue #(
        .DEPTH(OUT_DEPTH)
    ) u_out_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_push     (res_push),
        .res          (res),
        .res_full     (res_full),
        .empty        (empty),
        .pop          (pop),
        .line_bit     (line_bit),
        .is_stuffed   (is_stuffed),
        .last_of_item (last_of_item)
    );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the HDLC line encoder: bit stuffing, NRZI and scrambling.
// Depends on hbsn_pkg and hdlc_bit_stuff_nrzi_scrambler_top; reads no files.
`timescale 1ns / 1ps

module tb_top;

    // The fourth line mode has no name in the package; it must act as plain bits.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [7:0] FLAG_OCTET = 8'h7E;
    localparam int RUN_LIMIT = 200000;
    localparam int MAX_BITS = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic line_mode_we = 1'b0;
    logic [1:0] line_mode_wdata = 2'd0;
    logic push = 1'b0;
    logic full;
    logic func = hbsn_pkg::FUNC_DATA;
    logic [7:0] data_byte = 8'd0;
    logic start_of_frame = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic line_bit;
    logic is_stuffed;
    logic last_of_item;

    // Bytes still to be offered, and line bits still to be seen.
    hbsn_pkg::item_t items_waiting[$];
    hbsn_pkg::result_t bits_due[$];
    hbsn_pkg::result_t want_bit;

    // Our own copy of the encoder state and its line mode.
    logic [1:0] mode_q = hbsn_pkg::LINE_MODE_RESET;
    logic nrzi_q = 1'b0;
    logic [hbsn_pkg::SCR_W-1:0] scr_q = '0;
    logic [2:0] ones_q = 3'd0;

    logic steady = 1'b0;
    int bad_bits = 0;
    int cycle_count = 0;

    always #4 clk = ~clk;

    hdlc_bit_stuff_nrzi_scrambler_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .line_mode_we    (line_mode_we),
        .line_mode_wdata (line_mode_wdata),
        .push            (push),
        .full            (full),
        .func            (func),
        .data_byte       (data_byte),
        .start_of_frame  (start_of_frame),
        .empty           (empty),
        .pop             (pop),
        .line_bit        (line_bit),
        .is_stuffed      (is_stuffed),
        .last_of_item    (last_of_item)
    );

    // Line coding of one bit: NRZI toggles on a zero, then the scrambler
    // mixes in taps 0 and 5 and shifts the result in at the top.
    function automatic logic code_bit(input logic b);
        logic s;
        if (mode_q != hbsn_pkg::MODE_NRZI && mode_q != hbsn_pkg::MODE_NRZI_SCR)
            return b;
        if (!b)
            nrzi_q = ~nrzi_q;
        if (mode_q == hbsn_pkg::MODE_NRZI)
            return nrzi_q;
        s = nrzi_q ^ scr_q[0] ^ scr_q[hbsn_pkg::SCR_TAP];
        scr_q = {s, scr_q[hbsn_pkg::SCR_W-1:1]};
        return s;
    endfunction

    // Works out the line bits of one accepted byte, stuffing zeros included.
    task automatic encode_item(input hbsn_pkg::item_t it);
        hbsn_pkg::result_t word [MAX_BITS];
        int n;
        logic b;
        n = 0;
        if (it.sof)
        begin
            nrzi_q = 1'b0;
            scr_q = '0;
            ones_q = 3'd0;
        end
        if (it.is_flag == hbsn_pkg::FUNC_FLAG)
            ones_q = 3'd0;
        for (int i = hbsn_pkg::BYTE_BITS - 1; i >= 0; i--)
        begin
            b = it.data_byte[i];
            word[n] = '{line_bit: code_bit(b), is_stuffed: 1'b0, last_of_item: 1'b0};
            n++;
            if (it.is_flag == hbsn_pkg::FUNC_DATA)
            begin
                ones_q = b ? ones_q + 3'd1 : 3'd0;
                if (ones_q >= hbsn_pkg::STUFF_RUN)
                begin
                    ones_q = 3'd0;
                    word[n] = '{line_bit: code_bit(1'b0), is_stuffed: 1'b1,
                                last_of_item: 1'b0};
                    n++;
                end
            end
        end
        word[n - 1].last_of_item = 1'b1;
        for (int k = 0; k < n; k++)
            bits_due = {bits_due, word[k]};
    endtask

    // Driver: offers the oldest waiting byte and predicts it once taken.
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
                encode_item(items_waiting.pop_front());
            if (items_waiting.size() != 0 && (steady || $urandom_range(0, 99) >= 10))
            begin
                push <= 1'b1;
                func <= items_waiting[0].is_flag;
                data_byte <= items_waiting[0].data_byte;
                start_of_frame <= items_waiting[0].sof;
            end
            else
                push <= 1'b0;
        end
    end

    // Monitor: checks every line bit taken against the oldest prediction.
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (bits_due.size() == 0)
                begin
                    $display("%0t: line bit with nothing expected: expected none, got %b/%b/%b",
                             $time, line_bit, is_stuffed, last_of_item);
                    bad_bits++;
                end
                else
                begin
                    want_bit = bits_due.pop_front();
                    if (line_bit !== want_bit.line_bit)
                    begin
                        $display("%0t: line_bit expected %b, got %b",
                                 $time, want_bit.line_bit, line_bit);
                        bad_bits++;
                    end
                    if (is_stuffed !== want_bit.is_stuffed)
                    begin
                        $display("%0t: is_stuffed expected %b, got %b",
                                 $time, want_bit.is_stuffed, is_stuffed);
                        bad_bits++;
                    end
                    if (last_of_item !== want_bit.last_of_item)
                    begin
                        $display("%0t: last_of_item expected %b, got %b",
                                 $time, want_bit.last_of_item, last_of_item);
                        bad_bits++;
                    end
                end
            end
            pop <= steady || $urandom_range(0, 99) >= 10;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_item(input logic f, input logic [7:0] v, input logic s);
        items_waiting = {items_waiting,
                         hbsn_pkg::item_t'{is_flag: f, sof: s, data_byte: v}};
    endtask

    // Waits until every byte is taken and every line bit has come out.
    task automatic drain();
        while (items_waiting.size() != 0 || bits_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_line_mode(input logic [1:0] m);
        @(posedge clk);
        line_mode_we <= 1'b1;
        line_mode_wdata <= m;
        @(posedge clk);
        line_mode_we <= 1'b0;
        mode_q = m;
    endtask

    // Mostly whole frames (opening flag, data, closing flag) with ones-heavy
    // data to provoke stuffing; the rest is loose items and unclosed frames.
    task automatic queue_traffic(input int count);
        int added;
        int len;
        logic [7:0] b;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
                added++;
            end
            else
            begin
                add_item(hbsn_pkg::FUNC_FLAG, FLAG_OCTET, 1'b1);
                len = $urandom_range(1, 6);
                repeat (len)
                begin
                    case ($urandom_range(0, 3))
                        0: b = 8'hFF;
                        1: b = 8'($urandom_range(0, 255) | $urandom_range(0, 255));
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    add_item(hbsn_pkg::FUNC_DATA, b, 1'b0);
                end
                added += len + 1;
                if ($urandom_range(0, 4) != 0)
                begin
                    add_item(hbsn_pkg::FUNC_FLAG, FLAG_OCTET, 1'b0);
                    added++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset mode: stuffing across bytes, a stuff after the last bit,
        // flags that clear the run and are never stuffed, and a mid-stream restart.
        add_item(hbsn_pkg::FUNC_FLAG, FLAG_OCTET, 1'b1);
        add_item(hbsn_pkg::FUNC_DATA, 8'hFF, 1'b0);
        add_item(hbsn_pkg::FUNC_DATA, 8'hFF, 1'b0);
        add_item(hbsn_pkg::FUNC_FLAG, FLAG_OCTET, 1'b0);
        add_item(hbsn_pkg::FUNC_DATA, 8'h1F, 1'b0);
        add_item(hbsn_pkg::FUNC_DATA, 8'h00, 1'b0);
        add_item(hbsn_pkg::FUNC_FLAG, 8'hFF, 1'b0);
        add_item(hbsn_pkg::FUNC_DATA, 8'hF8, 1'b0);
        add_item(hbsn_pkg::FUNC_DATA, FLAG_OCTET, 1'b0);
        add_item(hbsn_pkg::FUNC_DATA, 8'h80, 1'b1);
        add_item(hbsn_pkg::FUNC_FLAG, 8'h00, 1'b0);
        drain();

        // Plain bits.
        set_line_mode(hbsn_pkg::MODE_PLAIN);
        add_item(hbsn_pkg::FUNC_DATA, 8'hFF, 1'b1);
        add_item(hbsn_pkg::FUNC_DATA, 8'h1F, 1'b0);
        queue_traffic(40);
        drain();

        // NRZI only; the first byte carries on from the state left before.
        set_line_mode(hbsn_pkg::MODE_NRZI);
        add_item(hbsn_pkg::FUNC_DATA, 8'h00, 1'b0);
        queue_traffic(40);
        drain();

        // The unused mode must pass bits through and hold the line state.
        set_line_mode(MODE_UNUSED);
        add_item(hbsn_pkg::FUNC_DATA, 8'hFF, 1'b0);
        add_item(hbsn_pkg::FUNC_FLAG, FLAG_OCTET, 1'b0);
        queue_traffic(20);
        drain();

        // Full coding with no gaps on either side.
        set_line_mode(hbsn_pkg::MODE_NRZI_SCR);
        steady <= 1'b1;
        queue_traffic(40);
        drain();
        steady <= 1'b0;

        repeat (3)
        begin
            set_line_mode(2'($urandom_range(0, 3)));
            queue_traffic(30);
            drain();
        end

        repeat (20) @(posedge clk);
        if (bad_bits == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
